FILE: rtl/motion_magnitude_peak_meter_assert.svh
// Assertion macros for the motion magnitude peak meter.
// Each macro checks on the rising edge of clk and is disabled while arst_n is low.
`ifndef MOTION_MAGNITUDE_PEAK_METER_ASSERT_SVH
`define MOTION_MAGNITUDE_PEAK_METER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MMPM_ASSERT_IMPLIES(lbl, cond, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);
`define MMPM_ASSERT_NEXT(lbl, cond, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);
`else
`define MMPM_ASSERT_IMPLIES(lbl, cond, expr, msg)
`define MMPM_ASSERT_NEXT(lbl, cond, expr, msg)
`endif
`endif

FILE: rtl/mmpm_pkg.sv
// Package of the motion magnitude peak meter: widths, reset values, constants,
// register indexes and the microcode program. It depends on nothing.
package mmpm_pkg;

	localparam int ACCEL_W    = 16;
	localparam int MAG_W      = 16;
	localparam int MARGIN_W   = 10;
	localparam int CFG8_W     = 8;
	localparam int CFG_DATA_W = 10;
	localparam int SUM_W      = 32;
	localparam int MUL_W      = 18;
	localparam int PROD_W     = 36;
	localparam int STEP_W     = 4;
	localparam int ITER_W     = 4;
	localparam int DSAT_W     = 6;
	localparam int AVG_SUM_W  = 18;
	localparam int Q3_W       = 17;
	localparam int DEVP_W     = 14;
	localparam int Q43_W      = 9;

	localparam logic [MARGIN_W-1:0] MARGIN_RST = 10'd20;
	localparam logic [CFG8_W-1:0]   DECAY_RST  = 8'd12;
	localparam logic [CFG8_W-1:0]   LIMIT_RST  = 8'd118;
	localparam logic [CFG8_W-1:0]   HOLD_RST   = 8'd15;

	// floor(2^19 / 3) and floor(2^20 / 43); both underestimate by less than one.
	localparam logic [MUL_W-1:0] RECIP3       = 18'd174762;
	localparam int               RECIP3_SHIFT = 19;
	localparam logic [MUL_W-1:0] DEV_SCALE    = 18'd220;
	localparam logic [MUL_W-1:0] RECIP43      = 18'd24385;
	localparam int               RECIP43_SHIFT = 20;
	localparam logic [6:0]       DEV_DIV      = 7'd43;

	localparam logic [ITER_W-1:0] SQRT_ITER_LAST = 4'd15;

	typedef enum logic [1:0] {
		REG_WARNING_MARGIN,
		REG_METER_DECAY,
		REG_METER_LIMIT,
		REG_WARNING_HOLD
	} reg_index_t;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_SQX,
		OP_SQY,
		OP_SQZ,
		OP_SUM,
		OP_SQRT,
		OP_AVGV,
		OP_AVGM,
		OP_AVGC,
		OP_DIFF,
		OP_DEVM1,
		OP_DEVM2,
		OP_DEVC,
		OP_EMIT
	} op_t;

	typedef enum logic [1:0] {
		C_NEXT,
		C_WAIT_IN,
		C_LOOP,
		C_WAIT_OUT
	} cond_t;

	typedef struct packed {
		op_t                op;
		cond_t              cond;
		logic [STEP_W-1:0]  target;
	} uword_t;

	localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
	localparam logic [STEP_W-1:0] STEP_SQX  = 4'd1;
	localparam logic [STEP_W-1:0] STEP_SQRT = 4'd5;

	function automatic uword_t ucode(input logic [STEP_W-1:0] step);
		uword_t w;
		begin
			case (step)
				4'd0:    w = '{OP_IDLE,  C_WAIT_IN,  STEP_IDLE};
				4'd1:    w = '{OP_SQX,   C_NEXT,     STEP_IDLE};
				4'd2:    w = '{OP_SQY,   C_NEXT,     STEP_IDLE};
				4'd3:    w = '{OP_SQZ,   C_NEXT,     STEP_IDLE};
				4'd4:    w = '{OP_SUM,   C_NEXT,     STEP_IDLE};
				4'd5:    w = '{OP_SQRT,  C_LOOP,     STEP_SQRT};
				4'd6:    w = '{OP_AVGV,  C_NEXT,     STEP_IDLE};
				4'd7:    w = '{OP_AVGM,  C_NEXT,     STEP_IDLE};
				4'd8:    w = '{OP_AVGC,  C_NEXT,     STEP_IDLE};
				4'd9:    w = '{OP_DIFF,  C_NEXT,     STEP_IDLE};
				4'd10:   w = '{OP_DEVM1, C_NEXT,     STEP_IDLE};
				4'd11:   w = '{OP_DEVM2, C_NEXT,     STEP_IDLE};
				4'd12:   w = '{OP_DEVC,  C_NEXT,     STEP_IDLE};
				4'd13:   w = '{OP_EMIT,  C_WAIT_OUT, STEP_IDLE};
				default: w = '{OP_IDLE,  C_WAIT_OUT, STEP_IDLE};
			endcase
			return w;
		end
	endfunction

endpackage

FILE: rtl/mmpm_if.sv
// Request channels of the motion magnitude peak meter: the sample channel and the result channel.
// Depends on mmpm_pkg for the field widths.
interface mmpm_sample_if;
	import mmpm_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [ACCEL_W-1:0]  accel_x;
	logic signed [ACCEL_W-1:0]  accel_y;
	logic signed [ACCEL_W-1:0]  accel_z;
	logic                       meter_enable;
	modport source (output valid, accel_x, accel_y, accel_z, meter_enable, input ready);
	modport sink (input valid, accel_x, accel_y, accel_z, meter_enable, output ready);
endinterface

interface mmpm_result_if;
	import mmpm_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [MAG_W-1:0]     magnitude;
	logic [MAG_W-1:0]     running_average;
	logic                 warning;
	logic [CFG8_W-1:0]    meter_level;
	logic [CFG8_W-1:0]    hold_left;
	modport source (output valid, magnitude, running_average, warning, meter_level, hold_left,
		input ready);
	modport sink (input valid, magnitude, running_average, warning, meter_level, hold_left,
		output ready);
endinterface

FILE: rtl/motion_magnitude_peak_meter.sv
// Top level of the motion magnitude peak meter: microcode sequencer and its datapath.
// Depends on mmpm_pkg, the channel interfaces in mmpm_if.sv and the assertion macros.
//
// One request on the sample channel carries three signed accelerometer axes and
// meter_enable. The block returns one request on the result channel with the floor
// square root of the summed squares, the updated running average, the warning flag,
// the peak meter level and the warning hold countdown.
// A sample runs from acceptance to the result register through the sequencer program:
// three squaring steps on the shared 18 by 18 multiplier, a summing step, 16
// iterations of the bit-serial square root, then the steps for the average, the
// deviation scaling and the meter update. Samples are taken one at a time.
// The result sits in an output register; the next sample is accepted while it waits.
// If the receiver stalls, the sequencer holds at its last step until the register
// is free. Configuration is written through cfg_we, cfg_index and cfg_data while
// the block is idle; the user is bound to this, the block itself does not enforce it.
// Reset clears the average, meter and hold countdown and restores the default
// register values.
module motion_magnitude_peak_meter (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  mmpm_pkg::reg_index_t                   cfg_index,
	input  logic [mmpm_pkg::CFG_DATA_W-1:0]        cfg_data,
	mmpm_sample_if.sink                            sample,
	mmpm_result_if.source                          result
);
	import mmpm_pkg::*;

	logic [MARGIN_W-1:0]  margin_q;
	logic [CFG8_W-1:0]    decay_q;
	logic [CFG8_W-1:0]    limit_q;
	logic [CFG8_W-1:0]    hold_cfg_q;

	logic [STEP_W-1:0]    step_q;
	logic [STEP_W-1:0]    step_d;
	uword_t               uw;

	logic [MAG_W-1:0]     avg_q;
	logic [CFG8_W-1:0]    meter_q;
	logic [CFG8_W-1:0]    hold_q;
	logic                 res_valid_q;

	logic [ACCEL_W-1:0]   ax_q;
	logic [ACCEL_W-1:0]   ay_q;
	logic [ACCEL_W-1:0]   az_q;
	logic                 en_q;
	logic [PROD_W-1:0]    prod_q;
	logic [SUM_W-1:0]     sum_q;
	logic [SUM_W-1:0]     root_q;
	logic [ITER_W-1:0]    iter_q;
	logic [AVG_SUM_W-1:0] v_q;
	logic                 warn_q;
	logic [DSAT_W-1:0]    dsat_q;
	logic [DEVP_W-1:0]    p_q;

	logic [MAG_W-1:0]     res_mag_q;
	logic [MAG_W-1:0]     res_avg_q;
	logic                 res_warn_q;
	logic [CFG8_W-1:0]    res_meter_q;
	logic [CFG8_W-1:0]    res_hold_q;

	logic                 accept;
	logic                 out_free;
	logic [MUL_W-1:0]     mul_a;
	logic [MUL_W-1:0]     mul_b;
	logic [PROD_W-1:0]    mul_p;
	logic [MAG_W-1:0]     mag;
	logic [SUM_W:0]       sq_bit;
	logic [SUM_W:0]       sq_trial;
	logic                 sq_take;
	logic [Q3_W-1:0]      q3;
	logic [AVG_SUM_W-1:0] r3;
	logic                 inc3;
	logic [AVG_SUM_W-1:0] avg_rem;
	logic [MAG_W-1:0]     avg_next;
	logic [MAG_W:0]       diff;
	logic [MAG_W:0]       warn_level;
	logic [DSAT_W-1:0]    dsat;
	logic [Q43_W-1:0]     q43;
	logic [DEVP_W:0]      r43;
	logic                 inc43;
	logic [DEVP_W:0]      dev_rem;
	logic [Q43_W-1:0]     dev9;
	logic [CFG8_W-1:0]    dev;
	logic [CFG8_W-1:0]    meter_next;
	logic [CFG8_W-1:0]    hold_next;

	function automatic logic [ACCEL_W-1:0] abs_axis(input logic signed [ACCEL_W-1:0] a);
		return a[ACCEL_W-1] ? ACCEL_W'(-a) : a;
	endfunction

	assign uw       = ucode(step_q);
	assign accept   = sample.valid && sample.ready;
	assign out_free = !res_valid_q || result.ready;
	assign mag      = root_q[MAG_W-1:0];

	assign sample.ready           = (uw.cond == C_WAIT_IN);
	assign result.valid           = res_valid_q;
	assign result.magnitude       = res_mag_q;
	assign result.running_average = res_avg_q;
	assign result.warning         = res_warn_q;
	assign result.meter_level     = res_meter_q;
	assign result.hold_left       = res_hold_q;

	always_comb begin
		case (uw.cond)
			C_WAIT_IN:  step_d = accept ? STEP_W'(step_q + 1'b1) : step_q;
			C_LOOP:     step_d = (iter_q != '0) ? uw.target : STEP_W'(step_q + 1'b1);
			C_WAIT_OUT: step_d = out_free ? uw.target : step_q;
			default:    step_d = STEP_W'(step_q + 1'b1);
		endcase
	end

	always_comb begin
		case (uw.op)
			OP_SQX: begin
				mul_a = MUL_W'(ax_q);
				mul_b = MUL_W'(ax_q);
			end
			OP_SQY: begin
				mul_a = MUL_W'(ay_q);
				mul_b = MUL_W'(ay_q);
			end
			OP_SQZ: begin
				mul_a = MUL_W'(az_q);
				mul_b = MUL_W'(az_q);
			end
			OP_AVGM: begin
				mul_a = v_q;
				mul_b = RECIP3;
			end
			OP_DEVM1: begin
				mul_a = MUL_W'(dsat_q);
				mul_b = DEV_SCALE;
			end
			OP_DEVM2: begin
				mul_a = MUL_W'(prod_q[DEVP_W-1:0]);
				mul_b = RECIP43;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// One step of the restoring square root: the trial bit walks down two places per step.
	assign sq_bit   = (SUM_W+1)'(1) << {iter_q, 1'b0};
	assign sq_trial = {1'b0, root_q} + sq_bit;
	assign sq_take  = {1'b0, sum_q} >= sq_trial;

	// The reciprocal quotient is floor or one below it; one compare corrects it.
	assign q3       = prod_q[RECIP3_SHIFT +: Q3_W];
	assign r3       = v_q - AVG_SUM_W'({q3, 1'b0} + {1'b0, q3});
	assign inc3     = r3 >= AVG_SUM_W'(3);
	assign avg_rem  = inc3 ? AVG_SUM_W'(r3 - AVG_SUM_W'(3)) : r3;
	assign avg_next = MAG_W'(q3 + Q3_W'(inc3));

	// Deviations of 63 and up scale past any 8-bit limit, so they saturate early.
	assign diff       = {1'b0, mag} - {1'b0, avg_q};
	assign warn_level = {1'b0, avg_q} + (MAG_W+1)'(margin_q);
	assign dsat       = diff[MAG_W] ? '0 : ((|diff[MAG_W-1:DSAT_W]) ? '1 : diff[DSAT_W-1:0]);

	assign q43     = prod_q[RECIP43_SHIFT +: Q43_W];
	assign r43     = {1'b0, p_q} - (DEVP_W+1)'(q43 * DEV_DIV);
	assign inc43   = r43 >= (DEVP_W+1)'(DEV_DIV);
	assign dev_rem = inc43 ? (DEVP_W+1)'(r43 - (DEVP_W+1)'(DEV_DIV)) : r43;
	assign dev9    = Q43_W'(q43 + Q43_W'(inc43));
	assign dev     = (dev9 > Q43_W'(limit_q)) ? limit_q : dev9[CFG8_W-1:0];

	always_comb begin
		if (dev > meter_q) begin
			meter_next = dev;
		end else if (meter_q >= decay_q) begin
			meter_next = meter_q - decay_q;
		end else begin
			meter_next = '0;
		end
		if (warn_q) begin
			hold_next = hold_cfg_q;
		end else if (hold_q != '0) begin
			hold_next = hold_q - 1'b1;
		end else begin
			hold_next = hold_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q    <= MARGIN_RST;
			decay_q     <= DECAY_RST;
			limit_q     <= LIMIT_RST;
			hold_cfg_q  <= HOLD_RST;
			step_q      <= STEP_IDLE;
			avg_q       <= '0;
			meter_q     <= '0;
			hold_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			step_q <= step_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_WARNING_MARGIN: margin_q   <= cfg_data;
					REG_METER_DECAY:    decay_q    <= cfg_data[CFG8_W-1:0];
					REG_METER_LIMIT:    limit_q    <= cfg_data[CFG8_W-1:0];
					REG_WARNING_HOLD:   hold_cfg_q <= cfg_data[CFG8_W-1:0];
					default: ;
				endcase
			end
			if (uw.op == OP_AVGC) begin
				avg_q <= avg_next;
			end
			if (uw.op == OP_DEVC && en_q) begin
				meter_q <= meter_next;
				hold_q  <= hold_next;
			end
			if (uw.op == OP_EMIT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ax_q <= abs_axis(sample.accel_x);
			ay_q <= abs_axis(sample.accel_y);
			az_q <= abs_axis(sample.accel_z);
			en_q <= sample.meter_enable;
		end
		case (uw.op)
			OP_SQX, OP_AVGM, OP_DEVM1: begin
				prod_q <= mul_p;
			end
			OP_SQY: begin
				sum_q  <= prod_q[SUM_W-1:0];
				prod_q <= mul_p;
			end
			OP_SQZ: begin
				sum_q  <= sum_q + prod_q[SUM_W-1:0];
				prod_q <= mul_p;
			end
			OP_SUM: begin
				sum_q  <= sum_q + prod_q[SUM_W-1:0];
				root_q <= '0;
				iter_q <= SQRT_ITER_LAST;
			end
			OP_SQRT: begin
				if (sq_take) begin
					sum_q  <= sum_q - sq_trial[SUM_W-1:0];
					root_q <= (root_q >> 1) + sq_bit[SUM_W-1:0];
				end else begin
					root_q <= root_q >> 1;
				end
				iter_q <= iter_q - 1'b1;
			end
			OP_AVGV: begin
				v_q <= {1'b0, avg_q, 1'b0} + AVG_SUM_W'(mag);
			end
			OP_DIFF: begin
				warn_q <= {1'b0, mag} > warn_level;
				dsat_q <= dsat;
			end
			OP_DEVM2: begin
				p_q    <= prod_q[DEVP_W-1:0];
				prod_q <= mul_p;
			end
			OP_EMIT: begin
				if (out_free) begin
					res_mag_q   <= mag;
					res_avg_q   <= avg_q;
					res_warn_q  <= warn_q;
					res_meter_q <= meter_q;
					res_hold_q  <= hold_q;
				end
			end
			default: ;
		endcase
	end

	`include "motion_magnitude_peak_meter_assert.svh"

	`MMPM_ASSERT_NEXT(a_accept_starts, accept, step_q == STEP_SQX, "Accepted sample did not start the program.")
	`MMPM_ASSERT_IMPLIES(a_root_narrow, uw.op == OP_AVGV, root_q[SUM_W-1:MAG_W] == '0, "Square root exceeds 16 bits.")
	`MMPM_ASSERT_IMPLIES(a_avg_rem, uw.op == OP_AVGC, avg_rem < AVG_SUM_W'(3), "Average quotient correction failed.")
	`MMPM_ASSERT_IMPLIES(a_dev_rem, uw.op == OP_DEVC, dev_rem < (DEVP_W+1)'(DEV_DIV), "Deviation quotient correction failed.")
	`MMPM_ASSERT_NEXT(a_meter_kept, uw.op == OP_DEVC && !en_q, $stable(meter_q) && $stable(hold_q), "Meter changed while disabled.")

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench of motion_magnitude_peak_meter: directed and random accelerometer samples,
// each result checked against an in-bench model of magnitude, average, warning, meter and hold.
// Depends on mmpm_pkg, the channel interfaces in mmpm_if.sv and the block's top level.
module tb_top;
	import mmpm_pkg::*;

	localparam int DEV_GAIN = 220;
	localparam int DEV_DIVISOR = 43;
	localparam int DRAIN_CYCLES = 64;

	typedef struct {
		logic signed [ACCEL_W-1:0] x;
		logic signed [ACCEL_W-1:0] y;
		logic signed [ACCEL_W-1:0] z;
		logic                      enable;
	} accel_sample_t;

	typedef struct {
		logic [MAG_W-1:0]  magnitude;
		logic [MAG_W-1:0]  average;
		logic              warning;
		logic [CFG8_W-1:0] level;
		logic [CFG8_W-1:0] hold;
	} meter_reading_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	reg_index_t            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mmpm_sample_if sample_ch();
	mmpm_result_if result_ch();

	motion_magnitude_peak_meter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_ch),
		.result    (result_ch)
	);

	logic [MARGIN_W-1:0] margin_cfg;
	logic [CFG8_W-1:0]   decay_cfg;
	logic [CFG8_W-1:0]   limit_cfg;
	logic [CFG8_W-1:0]   hold_cfg;
	logic [MAG_W-1:0]    avg_state;
	logic [CFG8_W-1:0]   meter_state;
	logic [CFG8_W-1:0]   hold_state;

	meter_reading_t pending_readings[$];
	int errors = 0;
	int samples_sent = 0;
	int warnings_seen = 0;
	int disabled_seen = 0;
	int settings_used = 1;
	int burst_left = 0;
	bit gaps_on = 1'b1;
	bit stalls_on = 1'b1;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic meter_reading_t meter_step(input accel_sample_t s);
		longint sum;
		longint dev;
		logic [MAG_W-1:0] root;
		logic [MAG_W-1:0] trial;
		int next_avg;
		meter_reading_t r;
		sum = longint'(s.x) * longint'(s.x) + longint'(s.y) * longint'(s.y)
			+ longint'(s.z) * longint'(s.z);
		root = '0;
		for (int b = MAG_W - 1; b >= 0; b--) begin
			trial = root | (16'd1 << b);
			if (longint'(trial) * longint'(trial) <= sum) begin
				root = trial;
			end
		end
		next_avg = (int'(avg_state) * 2 + int'(root)) / 3;
		avg_state = next_avg[MAG_W-1:0];
		r.warning = int'(root) > int'(avg_state) + int'(margin_cfg);
		if (s.enable) begin
			dev = (longint'(root) - longint'(avg_state)) * DEV_GAIN / DEV_DIVISOR;
			if (dev < 0) begin
				dev = 0;
			end
			if (dev > longint'(limit_cfg)) begin
				dev = longint'(limit_cfg);
			end
			if (dev > longint'(meter_state)) begin
				meter_state = dev[CFG8_W-1:0];
			end else if (meter_state >= decay_cfg) begin
				meter_state = meter_state - decay_cfg;
			end else begin
				meter_state = '0;
			end
			if (r.warning) begin
				hold_state = hold_cfg;
			end else if (hold_state != 0) begin
				hold_state = hold_state - 1'b1;
			end
		end
		r.magnitude = root;
		r.average = avg_state;
		r.level = meter_state;
		r.hold = hold_state;
		return r;
	endfunction

	function automatic accel_sample_t make_sample(input int x, input int y, input int z,
		input bit enable);
		accel_sample_t s;
		s.x = x[ACCEL_W-1:0];
		s.y = y[ACCEL_W-1:0];
		s.z = z[ACCEL_W-1:0];
		s.enable = enable;
		return s;
	endfunction

	function automatic int noise(input int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic bit random_enable();
		return $urandom_range(0, 9) != 0;
	endfunction

	// Called at a falling edge; returns at a falling edge with no pending write to valid.
	task automatic send_sample(input accel_sample_t s);
		meter_reading_t r;
		sample_ch.valid <= 1'b1;
		sample_ch.accel_x <= s.x;
		sample_ch.accel_y <= s.y;
		sample_ch.accel_z <= s.z;
		sample_ch.meter_enable <= s.enable;
		do @(posedge clk); while (sample_ch.ready !== 1'b1);
		r = meter_step(s);
		pending_readings.push_back(r);
		samples_sent++;
		if (r.warning) begin
			warnings_seen++;
		end
		if (!s.enable) begin
			disabled_seen++;
		end
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			if (gaps_on) begin
				sample_ch.valid <= 1'b0;
				repeat ($urandom_range(0, 3) == 0 ? $urandom_range(20, 45) : $urandom_range(1, 6))
					@(negedge clk);
			end
		end
		burst_left--;
	endtask

	task automatic wait_for_readings();
		sample_ch.valid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DATA_W-1:0];
		@(negedge clk);
	endtask

	task automatic set_config(input int margin, input int decay, input int limit, input int hold);
		write_reg(REG_WARNING_MARGIN, margin);
		write_reg(REG_METER_DECAY, decay);
		write_reg(REG_METER_LIMIT, limit);
		write_reg(REG_WARNING_HOLD, hold);
		cfg_we <= 1'b0;
		margin_cfg = margin[MARGIN_W-1:0];
		decay_cfg = decay[CFG8_W-1:0];
		limit_cfg = limit[CFG8_W-1:0];
		hold_cfg = hold[CFG8_W-1:0];
		settings_used++;
	endtask

	// Mostly a device at rest near one g followed by a short shake, plus full-range and tiny noise.
	task automatic run_motion(input int count);
		int sent;
		int kind;
		int len;
		int base;
		sent = 0;
		while (sent < count) begin
			kind = $urandom_range(0, 99);
			if (kind < 60) begin
				base = $urandom_range(600, 1400) * ($urandom_range(0, 1) ? 1 : -1);
				len = $urandom_range(4, 16);
				for (int i = 0; i < len && sent < count; i++) begin
					send_sample(make_sample(noise(100), noise(100), base + noise(100),
						random_enable()));
					sent++;
				end
				len = $urandom_range(1, 4);
				for (int i = 0; i < len && sent < count; i++) begin
					send_sample(make_sample($urandom, $urandom, $urandom, random_enable()));
					sent++;
				end
			end else if (kind < 85) begin
				len = $urandom_range(1, 8);
				for (int i = 0; i < len && sent < count; i++) begin
					send_sample(make_sample($urandom, $urandom, $urandom, random_enable()));
					sent++;
				end
			end else begin
				len = $urandom_range(1, 8);
				for (int i = 0; i < len && sent < count; i++) begin
					send_sample(make_sample(noise(8), noise(8), noise(8), random_enable()));
					sent++;
				end
			end
		end
	endtask

	task automatic test_axis_extremes();
		send_sample(make_sample(0, 0, 0, 1'b1));
		send_sample(make_sample(-32768, -32768, -32768, 1'b1));
		send_sample(make_sample(32767, 32767, 32767, 1'b1));
		send_sample(make_sample(-32768, 0, 0, 1'b1));
		send_sample(make_sample(0, 32767, 0, 1'b1));
		send_sample(make_sample(0, 0, -1, 1'b1));
		send_sample(make_sample(1, -1, 1, 1'b1));
		send_sample(make_sample(-32768, 32767, -32768, 1'b1));
		repeat (3) send_sample(make_sample(0, 0, 0, 1'b1));
	endtask

	// With the meter off, magnitude and average still move while meter and hold stay put.
	task automatic test_meter_disabled();
		send_sample(make_sample(-32768, -32768, -32768, 1'b0));
		send_sample(make_sample(0, 0, 0, 1'b0));
		send_sample(make_sample(1000, -1000, 500, 1'b0));
		send_sample(make_sample(0, 0, 0, 1'b1));
	endtask

	// A meter left above a newly lowered limit must decay rather than be cut.
	task automatic test_lowered_limit();
		wait_for_readings();
		set_config(20, 1, 255, 15);
		send_sample(make_sample(-32768, -32768, -32768, 1'b1));
		wait_for_readings();
		set_config(20, 1, 5, 15);
		repeat (4) send_sample(make_sample(0, 0, 0, 1'b1));
	endtask

	task automatic test_default_settings();
		wait_for_readings();
		set_config(int'(MARGIN_RST), int'(DECAY_RST), int'(LIMIT_RST), int'(HOLD_RST));
		run_motion(270);
	endtask

	task automatic test_register_extremes();
		wait_for_readings();
		set_config(0, 0, 255, 255);
		run_motion(270);
		wait_for_readings();
		set_config(1023, 255, 0, 0);
		run_motion(270);
	endtask

	task automatic test_random_settings();
		wait_for_readings();
		set_config($urandom_range(0, 1023), $urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 255));
		run_motion(270);
		wait_for_readings();
		set_config($urandom_range(0, 200), $urandom_range(0, 40), $urandom_range(40, 255),
			$urandom_range(0, 40));
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		run_motion(270);
		gaps_on = 1'b1;
		stalls_on = 1'b1;
	endtask

	initial begin
		int left;
		bit open;
		result_ch.ready = 1'b0;
		left = 0;
		open = 1'b0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				open = !open;
				left = open ? $urandom_range(1, 40)
					: ($urandom_range(0, 3) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 4));
			end
			left--;
			result_ch.ready <= open || !stalls_on;
		end
	end

	always @(posedge clk) begin
		meter_reading_t want;
		if (arst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (pending_readings.size() == 0) begin
				$error("result request with no sample outstanding");
				errors++;
			end else begin
				want = pending_readings.pop_front();
				if (result_ch.magnitude !== want.magnitude) begin
					$error("magnitude: expected %0d, actual %0d", want.magnitude,
						result_ch.magnitude);
					errors++;
				end
				if (result_ch.running_average !== want.average) begin
					$error("running_average: expected %0d, actual %0d", want.average,
						result_ch.running_average);
					errors++;
				end
				if (result_ch.warning !== want.warning) begin
					$error("warning: expected %0d, actual %0d", want.warning, result_ch.warning);
					errors++;
				end
				if (result_ch.meter_level !== want.level) begin
					$error("meter_level: expected %0d, actual %0d", want.level,
						result_ch.meter_level);
					errors++;
				end
				if (result_ch.hold_left !== want.hold) begin
					$error("hold_left: expected %0d, actual %0d", want.hold, result_ch.hold_left);
					errors++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_WARNING_MARGIN;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.accel_x = '0;
		sample_ch.accel_y = '0;
		sample_ch.accel_z = '0;
		sample_ch.meter_enable = 1'b0;
		margin_cfg = MARGIN_RST;
		decay_cfg = DECAY_RST;
		limit_cfg = LIMIT_RST;
		hold_cfg = HOLD_RST;
		avg_state = '0;
		meter_state = '0;
		hold_state = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_axis_extremes();
		test_meter_disabled();
		test_lowered_limit();
		test_default_settings();
		test_register_extremes();
		test_random_settings();

		wait_for_readings();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d samples over %0d register settings: %0d warnings raised,",
			samples_sent, settings_used, warnings_seen);
		$display("%0d samples with the meter disabled, %0d field mismatches.",
			disabled_seen, errors);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
